// ----- design/rse_pkg.sv -----
// Shared types, constants and helper functions for the radix symbol encoder.
package rse_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MaxSymbolsDefault = 128;
  localparam int unsigned ValueBitsDefault  = 32;

  // Fixed field widths.
  localparam int unsigned ValueW   = 32;
  localparam int unsigned SymIdxW  = 7;
  localparam int unsigned CharW    = 8;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Command queue depth and quotient bits resolved per divider cycle.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned DivStep  = 8;

  localparam logic [CharW-1:0] SpaceChar = 8'd32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRadix       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSymbolCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDigitShift  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPadEnable   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpaceEnable = 3'd4;

  localparam logic [7:0] RadixReset       = 8'd95;
  localparam logic [7:0] SymbolCountReset = 8'd95;

  typedef enum logic {
    OP_CONVERT     = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ValueW-1:0]  value;
    logic [SymIdxW-1:0] sym_idx;
    logic [CharW-1:0]   sym_char;
  } cmd_t;

  typedef struct packed {
    logic [7:0] radix;
    logic [7:0] symbol_count;
    logic [6:0] digit_shift;
    logic       pad_enable;
    logic       space_enable;
  } cfg_t;

  // Reset contents of the symbol table: digits, upper, lower, then punctuation.
  function automatic logic [CharW-1:0] default_symbol(input logic [7:0] i);
    logic [CharW-1:0] s;
    if (i < 8'd10) begin
      s = 8'd48 + i;
    end else if (i < 8'd36) begin
      s = 8'd65 + (i - 8'd10);
    end else if (i < 8'd62) begin
      s = 8'd97 + (i - 8'd36);
    end else if (i < 8'd78) begin
      s = 8'd32 + (i - 8'd62);
    end else if (i < 8'd85) begin
      s = 8'd58 + (i - 8'd78);
    end else if (i < 8'd91) begin
      s = 8'd91 + (i - 8'd85);
    end else if (i < 8'd95) begin
      s = 8'd123 + (i - 8'd91);
    end else begin
      s = 8'd0;
    end
    return s;
  endfunction

  // Digits needed for one byte: smallest k with radix**k >= 255, clamped to 2..8.
  function automatic logic [3:0] digit_width(input logic [7:0] radix);
    logic [3:0] w;
    if (radix <= 8'd2) begin
      w = 4'd8;
    end else if (radix == 8'd3) begin
      w = 4'd6;
    end else if (radix <= 8'd6) begin
      w = 4'd4;
    end else if (radix <= 8'd15) begin
      w = 4'd3;
    end else begin
      w = 4'd2;
    end
    return w;
  endfunction

  // Eight restoring steps: x mod m for narrow operands, m nonzero.
  function automatic logic [7:0] mod_small(input logic [7:0] x, input logic [7:0] m);
    logic [8:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[7:0], x[i]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r[7:0];
  endfunction

endpackage

// ----- design/radix_symbol_encoder.sv -----
// Top level of the radix symbol encoder: configuration registers and part wiring.
//
// Usage: each slave-side transfer carries one command. tuser 0 converts the
// value in tdata to a digit string in the configured radix; tuser 1 writes one
// symbol table entry and emits nothing. A conversion emits one character per
// master-side transfer, most significant digit first (optionally after leading
// spaces and zero-symbol padding), with tlast on the final character.
// The back part writes a table entry from idle and takes the next command only
// once the current one is done. A conversion divides by the radix once per
// digit, keeps digits below the symbol count, then emits spaces, zero symbols
// and kept digits. The divider resolves 8 quotient bits per cycle, and each
// symbol takes a rotate, a modulo by the symbol count and one symbol RAM read.
// A two-entry command queue lets the front keep taking transfers while the
// back part works or the receiver stalls; a stalled receiver holds the output
// register and the back part waits. Reset restores the register defaults and
// marks every table entry unwritten, so the table reads as the reset alphabet
// at once. Write the configuration port only while the block is idle.
module radix_symbol_encoder #(
  parameter int unsigned MAX_SYMBOLS = rse_pkg::MaxSymbolsDefault,
  parameter int unsigned VALUE_BITS  = rse_pkg::ValueBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // value[31:0], symbol_index[38:32], symbol_char[46:39], zero fill [47]
  input  logic [rse_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_char[7:0]
  output logic [rse_pkg::OutDataW-1:0]  m_axis_tdata,
  // last
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rse_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rse_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);

  cfg_t             cfg_q, cfg_d;
  cmd_t             front_cmd;
  cmd_t             head_cmd;
  logic [CMD_W-1:0] head_bits;
  logic             push, pop, full, empty;

  // Configuration writes land directly; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRadix:       cfg_d.radix        = cfg_data_i;
        RegSymbolCount: cfg_d.symbol_count = cfg_data_i;
        RegDigitShift:  cfg_d.digit_shift  = cfg_data_i[6:0];
        RegPadEnable:   cfg_d.pad_enable   = cfg_data_i[0];
        RegSpaceEnable: cfg_d.space_enable = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix        <= RadixReset;
      cfg_q.symbol_count <= SymbolCountReset;
      cfg_q.digit_shift  <= '0;
      cfg_q.pad_enable   <= 1'b0;
      cfg_q.space_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take transfers, drop ones that do nothing, queue the rest.
  rse_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // Queue: decouples acceptance from execution.
  rse_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (CMD_W'(front_cmd)),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_bits),
    .empty_o (empty)
  );

  assign head_cmd = cmd_t'(head_bits);

  // Back: divide, look up symbols and stream characters out.
  rse_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- design/rse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rse_fifo.sv -----
// Short command queue between the front and back parts.
module rse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- design/rse_front.sv -----
// Front part: accepts input transfers, classifies them and queues commands.
module rse_front #(
  parameter int unsigned MAX_SYMBOLS = 128,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rse_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  rse_pkg::cfg_t                 cfg_i,
  input  logic                          full_i,
  output logic                          push_o,
  output rse_pkg::cmd_t                 cmd_o
);
  import rse_pkg::*;

  localparam int unsigned DATA_W = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;

  logic [ValueW-1:0]  value;
  logic [SymIdxW-1:0] sym_idx;
  logic [CharW-1:0]   sym_char;
  logic               keep;

  assign value    = s_axis_tdata[ValueW-1:0];
  assign sym_idx  = s_axis_tdata[ValueW+SymIdxW-1:ValueW];
  assign sym_char = s_axis_tdata[ValueW+SymIdxW+CharW-1:ValueW+SymIdxW];

  assign s_axis_tready = !full_i;

  always_comb begin
    cmd_o.value    = ValueW'(value[DATA_W-1:0]);
    cmd_o.sym_idx  = sym_idx;
    cmd_o.sym_char = sym_char;
    if (s_axis_tuser) begin
      cmd_o.op = OP_TABLE_WRITE;
      // drop writes past the end of the table
      keep     = (9'(sym_idx) < 9'(MAX_SYMBOLS));
    end else begin
      cmd_o.op = OP_CONVERT;
      // radix 0 or 1 produces nothing
      keep     = (cfg_i.radix >= 8'd2);
    end
  end

  assign push_o = s_axis_tvalid && !full_i && keep;

endmodule

// ----- design/rse_back.sv -----
// Back part: digit extraction, symbol lookup and character emission.
module rse_back #(
  parameter int unsigned MAX_SYMBOLS = 128,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rse_pkg::cfg_t                cfg_i,
  input  rse_pkg::cmd_t                cmd_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rse_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import rse_pkg::*;

  localparam int unsigned DATA_W  = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned DIV_CYC = (DATA_W + DivStep - 1) / DivStep;
  localparam int unsigned DIV_W   = DIV_CYC * DivStep;
  localparam int unsigned CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int unsigned IDX_W   = $clog2(MAX_SYMBOLS);
  localparam int unsigned BUF_AW  = $clog2(DATA_W);
  localparam int unsigned CNT_W   = $clog2(DATA_W + 1);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_SETUP  = 4'd1;
  localparam logic [ST_W-1:0] S_DIV    = 4'd2;
  localparam logic [ST_W-1:0] S_PLAN   = 4'd3;
  localparam logic [ST_W-1:0] S_NEXT   = 4'd4;
  localparam logic [ST_W-1:0] S_RDBUF  = 4'd5;
  localparam logic [ST_W-1:0] S_MAPADD = 4'd6;
  localparam logic [ST_W-1:0] S_MAPMOD = 4'd7;
  localparam logic [ST_W-1:0] S_TAB    = 4'd8;
  localparam logic [ST_W-1:0] S_OUT    = 4'd9;

  logic [ST_W-1:0]        state_q, state_d;
  logic [CNT_W-1:0]       dc_q, dc_d;
  logic [3:0]             sp_q, sp_d;
  logic [3:0]             nz_q, nz_d;
  logic [CYC_W-1:0]       cyc_q, cyc_d;
  logic [MAX_SYMBOLS-1:0] sym_vld_q, sym_vld_d;
  logic                   out_valid_q, out_valid_d;

  logic [DIV_W-1:0]  a_q, a_d;
  logic [7:0]        rem_q, rem_d;
  logic              zero_q, zero_d;
  logic [7:0]        soff_q, soff_d;
  logic [3:0]        wid_q, wid_d;
  logic [7:0]        r_q, r_d;
  logic [7:0]        x_q, x_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              last_q, last_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              vld_rd_q, vld_rd_d;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;

  logic [7:0]        cnt;
  logic [DIV_W-1:0]  div_quo;
  logic [7:0]        div_rem;
  logic [8:0]        div_tmp;
  logic              keep_digit;
  logic [8:0]        map_sum;
  logic [7:0]        x_n;
  logic [IDX_W-1:0]  idx_n;
  logic [6:0]        w7, dc7, nz7, tot7, sp7;
  logic              out_load;

  logic              tab_we, tab_re;
  logic [IDX_W-1:0]  tab_waddr;
  logic [CharW-1:0]  tab_rdata;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [IDX_W-1:0]  buf_rdata;

  // active symbol count, capped at the table size
  always_comb begin
    if ({1'b0, cfg_i.symbol_count} > 9'(MAX_SYMBOLS)) begin
      cnt = 8'(MAX_SYMBOLS);
    end else begin
      cnt = cfg_i.symbol_count;
    end
  end

  // restoring divider, DivStep quotient bits per cycle
  always_comb begin
    div_rem = rem_q;
    div_quo = a_q;
    div_tmp = '0;
    for (int i = 0; i < DivStep; i++) begin
      div_tmp = {div_rem, div_quo[DIV_W-1]};
      div_quo = {div_quo[DIV_W-2:0], 1'b0};
      if (div_tmp >= {1'b0, cfg_i.radix}) begin
        div_tmp    = div_tmp - {1'b0, cfg_i.radix};
        div_quo[0] = 1'b1;
      end
      div_rem = div_tmp[7:0];
    end
  end

  assign keep_digit = (div_rem < cnt);

  // digit rotation and table index
  assign map_sum = {1'b0, r_q} + {1'b0, soff_q};
  assign x_n     = (map_sum >= {1'b0, cfg_i.radix}) ?
                   8'(map_sum - {1'b0, cfg_i.radix}) : map_sum[7:0];
  assign idx_n   = (cnt == 8'd0) ? '0 : IDX_W'(mod_small(x_q, cnt));

  // run plan: zero symbols and leading spaces
  always_comb begin
    w7  = 7'(wid_q);
    dc7 = 7'(dc_q);
    if (zero_q) begin
      nz7 = cfg_i.pad_enable ? w7 : 7'd1;
    end else if (cfg_i.pad_enable && (w7 > dc7)) begin
      nz7 = w7 - dc7;
    end else begin
      nz7 = 7'd0;
    end
    tot7 = dc7 + nz7;
    if (cfg_i.space_enable) begin
      sp7 = ((w7 > tot7) ? (w7 - tot7) : 7'd0) + 7'd1;
    end else begin
      sp7 = 7'd0;
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    dc_d      = dc_q;
    sp_d      = sp_q;
    nz_d      = nz_q;
    cyc_d     = cyc_q;
    sym_vld_d = sym_vld_q;
    a_d       = a_q;
    rem_d     = rem_q;
    zero_d    = zero_q;
    soff_d    = soff_q;
    wid_d     = wid_q;
    r_d       = r_q;
    x_d       = x_q;
    idx_d     = idx_q;
    last_d    = last_q;
    char_d    = char_q;
    vld_rd_d  = vld_rd_q;
    pop_o     = 1'b0;
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_waddr = IDX_W'(cmd_i.sym_idx);
    buf_we    = 1'b0;
    buf_re    = 1'b0;
    buf_waddr = BUF_AW'(dc_q);
    buf_raddr = BUF_AW'(dc_q - 1'b1);

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.op == OP_TABLE_WRITE) begin
            tab_we               = 1'b1;
            sym_vld_d[tab_waddr] = 1'b1;
          end else begin
            a_d     = DIV_W'(cmd_i.value[DATA_W-1:0]);
            rem_d   = '0;
            cyc_d   = '0;
            dc_d    = '0;
            zero_d  = (cmd_i.value[DATA_W-1:0] == '0);
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        soff_d  = mod_small({1'b0, cfg_i.digit_shift}, cfg_i.radix);
        wid_d   = digit_width(cfg_i.radix);
        state_d = zero_q ? S_PLAN : S_DIV;
      end
      S_DIV: begin
        a_d   = div_quo;
        rem_d = div_rem;
        if (cyc_q == CYC_W'(DIV_CYC - 1)) begin
          cyc_d = '0;
          rem_d = '0;
          if (keep_digit) begin
            buf_we = 1'b1;
            dc_d   = dc_q + 1'b1;
          end
          if (div_quo == '0) begin
            state_d = S_PLAN;
          end
        end else begin
          cyc_d = cyc_q + 1'b1;
        end
      end
      S_PLAN: begin
        nz_d    = 4'(nz7);
        sp_d    = 4'(sp7);
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (sp_q != 4'd0) begin
          sp_d    = sp_q - 1'b1;
          char_d  = SpaceChar;
          last_d  = (sp_q == 4'd1) && (nz_q == 4'd0) && (dc_q == '0);
          state_d = S_OUT;
        end else if (nz_q != 4'd0) begin
          nz_d    = nz_q - 1'b1;
          r_d     = '0;
          last_d  = (nz_q == 4'd1) && (dc_q == '0);
          state_d = S_MAPADD;
        end else if (dc_q != '0) begin
          dc_d    = dc_q - 1'b1;
          buf_re  = 1'b1;
          last_d  = (dc_q == CNT_W'(1));
          state_d = S_RDBUF;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RDBUF: begin
        r_d     = 8'(buf_rdata);
        state_d = S_MAPADD;
      end
      S_MAPADD: begin
        x_d     = x_n;
        state_d = S_MAPMOD;
      end
      S_MAPMOD: begin
        idx_d    = idx_n;
        tab_re   = 1'b1;
        vld_rd_d = sym_vld_q[idx_n];
        state_d  = S_TAB;
      end
      S_TAB: begin
        // entries never written read as the reset alphabet
        char_d  = vld_rd_q ? tab_rdata : default_symbol(8'(idx_q));
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dc_q        <= '0;
      sp_q        <= '0;
      nz_q        <= '0;
      cyc_q       <= '0;
      sym_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dc_q        <= dc_d;
      sp_q        <= sp_d;
      nz_q        <= nz_d;
      cyc_q       <= cyc_d;
      sym_vld_q   <= sym_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    rem_q    <= rem_d;
    zero_q   <= zero_d;
    soff_q   <= soff_d;
    wid_q    <= wid_d;
    r_q      <= r_d;
    x_q      <= x_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
    char_q   <= char_d;
    vld_rd_q <= vld_rd_d;
    if (out_load) begin
      out_char_q <= char_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  rse_ram #(
    .WIDTH (CharW),
    .DEPTH (MAX_SYMBOLS)
  ) u_symbol_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (cmd_i.sym_char),
    .re_i    (tab_re),
    .raddr_i (idx_n),
    .rdata_o (tab_rdata)
  );

  rse_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DATA_W)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (IDX_W'(div_rem)),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  a_digit_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= CNT_W'(DATA_W))
    else $error("digit count exceeds value width");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < cfg_i.radix))
    else $error("partial remainder not below radix");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !m_axis_tready) |=> (state_q == S_OUT))
    else $error("character left output stage while receiver stalled");

  a_plan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nz_q <= 4'd8) && (sp_q <= 4'd9))
    else $error("pad or space count out of range");

endmodule
